// ===== hdl/utf16_to_utf8_transcoder_unit_defines.svh =====
// Assertion shorthands shared by the transcoder RTL.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define U16U8_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define U16U8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/u16u8_pkg.sv =====
package u16u8_pkg;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_ODD      = 3'd1;
	localparam logic [2:0] ERR_TRUNC    = 3'd2;
	localparam logic [2:0] ERR_BAD_LOW  = 3'd3;
	localparam logic [2:0] ERR_LONE_LOW = 3'd4;

	localparam logic [5:0] SURR_HI_TAG = 6'b110110;
	localparam logic [5:0] SURR_LO_TAG = 6'b110111;

	localparam logic [7:0] BOM_A = 8'hFF;
	localparam logic [7:0] BOM_B = 8'hFE;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	localparam logic [20:0] SUPP_BASE = 21'h10000;

	localparam logic [2:0] MAX_DATA = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       message_end;
		logic [2:0] error_code;
	} out_item_t;

	// Work for one input byte: up to four data bytes, then an optional status word.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      n_data;
		logic            stat;
		logic [2:0]      code;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== hdl/u16u8_front.sv =====
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module u16u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u16u8_pkg::in_item_t in_item,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  u16u8_pkg::q_stat_t  qstat,
	output logic                job_push,
	output u16u8_pkg::job_t     job
);
	import u16u8_pkg::*;

	logic        acc;
	logic        little_endian_q;
	logic [7:0]  held_byte_q;
	logic        have_half_q, have_half_nxt;
	logic        first_pending_q, first_pending_nxt;
	logic        seen_two_q, seen_two_nxt;
	logic [9:0]  hs_bits_q, hs_bits_nxt;
	logic        hs_pend_q, hs_pend_nxt;
	logic [2:0]  sticky_q, sticky_nxt;
	logic [7:0]  a, b;
	logic [15:0] unit;
	logic        bom, is_hi, is_lo;
	logic [20:0] cp;

	assign acc = push && !qstat.full;
	assign a   = held_byte_q;
	assign b   = in_item.in_byte;
	assign unit = little_endian_q ? {b, a} : {a, b};
	assign bom  = first_pending_q && ((a == BOM_A && b == BOM_B) || (a == BOM_B && b == BOM_A));
	assign is_hi = unit[15:10] == SURR_HI_TAG;
	assign is_lo = unit[15:10] == SURR_LO_TAG;
	assign cp    = SUPP_BASE + {1'b0, hs_bits_q, unit[9:0]};

	always_comb begin
		have_half_nxt     = have_half_q;
		first_pending_nxt = first_pending_q;
		seen_two_nxt      = seen_two_q;
		hs_bits_nxt       = hs_bits_q;
		hs_pend_nxt       = hs_pend_q;
		sticky_nxt        = sticky_q;
		job               = '0;
		job.code          = ERR_OK;

		if (!have_half_q) begin
			have_half_nxt = 1'b1;
		end else begin
			have_half_nxt     = 1'b0;
			seen_two_nxt      = 1'b1;
			first_pending_nxt = 1'b0;
			if (!bom && sticky_q == ERR_OK) begin
				if (hs_pend_q) begin
					hs_pend_nxt = 1'b0;
					if (is_lo) begin
						job.data[0] = LEAD4 | {5'd0, cp[20:18]};
						job.data[1] = CONT | {2'd0, cp[17:12]};
						job.data[2] = CONT | {2'd0, cp[11:6]};
						job.data[3] = CONT | {2'd0, cp[5:0]};
						job.n_data  = MAX_DATA;
					end else begin
						sticky_nxt = ERR_BAD_LOW;
					end
				end else if (is_hi) begin
					hs_bits_nxt = unit[9:0];
					hs_pend_nxt = 1'b1;
				end else if (is_lo) begin
					sticky_nxt = ERR_LONE_LOW;
				end else if (unit[15:7] == '0) begin
					job.data[0] = unit[7:0];
					job.n_data  = 3'd1;
				end else if (unit[15:11] == '0) begin
					job.data[0] = LEAD2 | {3'd0, unit[10:6]};
					job.data[1] = CONT | {2'd0, unit[5:0]};
					job.n_data  = 3'd2;
				end else begin
					job.data[0] = LEAD3 | {4'd0, unit[15:12]};
					job.data[1] = CONT | {2'd0, unit[11:6]};
					job.data[2] = CONT | {2'd0, unit[5:0]};
					job.n_data  = 3'd3;
				end
			end
		end

		if (in_item.last_in_message) begin
			job.stat = 1'b1;
			priority if (have_half_nxt) begin
				job.code = seen_two_nxt ? ERR_ODD : ERR_OK;
			end else if (sticky_nxt != ERR_OK) begin
				job.code = sticky_nxt;
			end else if (hs_pend_nxt) begin
				job.code = ERR_TRUNC;
			end else begin
				job.code = ERR_OK;
			end
			// close the message: back to the idle state
			have_half_nxt     = 1'b0;
			first_pending_nxt = 1'b1;
			seen_two_nxt      = 1'b0;
			hs_bits_nxt       = '0;
			hs_pend_nxt       = 1'b0;
			sticky_nxt        = ERR_OK;
		end
	end

	assign job_push = acc && (job.n_data != 3'd0 || job.stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b1;
			have_half_q     <= 1'b0;
			first_pending_q <= 1'b1;
			seen_two_q      <= 1'b0;
			hs_bits_q       <= '0;
			hs_pend_q       <= 1'b0;
			sticky_q        <= ERR_OK;
		end else begin
			if (cfg_we) begin
				little_endian_q <= cfg_wdata;
			end
			if (acc) begin
				have_half_q     <= have_half_nxt;
				first_pending_q <= first_pending_nxt;
				seen_two_q      <= seen_two_nxt;
				hs_bits_q       <= hs_bits_nxt;
				hs_pend_q       <= hs_pend_nxt;
				sticky_q        <= sticky_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !have_half_q) begin
			held_byte_q <= b;
		end
	end

	`U16U8_ASSERT(a_err_excl_pend, clk, arst_n, !(sticky_q != ERR_OK && hs_pend_q), "error and pending high surrogate together")
	`U16U8_ASSERT_NEXT(a_last_clears, clk, arst_n, acc && in_item.last_in_message, !have_half_q && first_pending_q && sticky_q == ERR_OK && !hs_pend_q, "message state not cleared after last word")
	`U16U8_ASSERT(a_data_bound, clk, arst_n, !job_push || job.n_data <= MAX_DATA, "job holds too many data words")

endmodule

// ===== hdl/u16u8_jobq.sv =====
module u16u8_jobq #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_push,
	input  u16u8_pkg::job_t    job_in,
	input  logic               deq,
	output u16u8_pkg::job_t    head,
	output u16u8_pkg::q_stat_t qstat
);
	import u16u8_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign qstat.empty = count_q == '0;
	assign qstat.full  = count_q == CW'(DEPTH);
	assign do_push = job_push && !qstat.full;
	assign do_pop  = deq && !qstat.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/u16u8_back.sv =====
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::job_t      head,
	input  u16u8_pkg::q_stat_t   qstat,
	input  logic                 pop,
	output u16u8_pkg::out_item_t out_item,
	output logic                 deq
);
	import u16u8_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_data;
	logic       take;

	assign total   = head.n_data + {2'd0, head.stat};
	assign is_data = idx_q < head.n_data;
	assign take    = pop && !qstat.empty;

	always_comb begin
		out_item = '0;
		if (is_data) begin
			out_item.out_byte   = head.data[idx_q[1:0]];
			out_item.byte_valid = 1'b1;
			out_item.error_code = ERR_OK;
		end else begin
			out_item.message_end = 1'b1;
			out_item.error_code  = head.code;
		end
		out_item.run_last = (idx_q + 3'd1) == total;
	end

	// release the job after its final word
	assign deq = take && out_item.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= out_item.run_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	`U16U8_ASSERT(a_idx_in_job, clk, arst_n, qstat.empty || idx_q < total, "word index past end of job")
	`U16U8_ASSERT(a_status_last, clk, arst_n, qstat.empty || out_item.byte_valid || out_item.run_last, "status word not last of its job")
	`U16U8_ASSERT_NEXT(a_deq_rewinds, clk, arst_n, deq, idx_q == 3'd0, "index not rewound after job")

endmodule

// ===== hdl/utf16_to_utf8_transcoder_unit.sv =====
// Channel   Handshake         Word
// input     push / full       in_item  : in_byte, last_in_message
// output    pop / empty       out_item : out_byte, byte_valid, run_last, message_end, error_code
// config    cfg_we            cfg_wdata: little_endian
//
// An input word is taken whenever push is high and the job queue has room; the front decodes
// it completely in that cycle and queues its 1 to 5 output words as one job, if there are any.
// The back hands out one output word per cycle while pop is high and a job is queued, so
// sustained throughput is set by the output side, which spends one pop on each result.
// The job queue holds DEPTH jobs; full rises only when it holds DEPTH undelivered jobs.
// Reset clears the message state and the queue and sets little_endian to 1.
module utf16_to_utf8_transcoder_unit #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  u16u8_pkg::in_item_t  in_item,
	input  logic                 pop,
	output logic                 empty,
	output u16u8_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	import u16u8_pkg::*;

	q_stat_t qstat;
	job_t    job, head;
	logic    job_push, deq;

	assign full  = qstat.full;
	assign empty = qstat.empty;

	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.qstat    (qstat),
		.job_push (job_push),
		.job      (job)
	);

	u16u8_jobq #(
		.DEPTH(DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_push(job_push),
		.job_in  (job),
		.deq     (deq),
		.head    (head),
		.qstat   (qstat)
	);

	u16u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.out_item(out_item),
		.deq     (deq)
	);

endmodule

// ===== sim/utf16_to_utf8_transcoder_unit_tb.sv =====
module utf16_to_utf8_transcoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u16u8_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 80;
	localparam int RANDOM_WORDS  = 135;
	localparam int PRINT_LIMIT   = 30;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  in_item = '0;
	logic      pop = 1'b0;
	logic      empty;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	// Transcoder state as the block should hold it
	logic        cfg_little_endian = 1'b1;
	logic [7:0]  held_lead = '0;
	logic        lead_waiting = 1'b0;
	logic        awaiting_first_unit = 1'b1;
	logic        unit_seen = 1'b0;
	logic [9:0]  pair_high_bits = '0;
	logic        pair_open = 1'b0;
	logic [2:0]  msg_error = ERR_OK;

	out_item_t utf8_expect[$];

	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycle_count = 0;

	// Sender burst control
	logic sender_bursty = 1'b1;
	int   burst_left = 0;

	// Receiver stall control
	logic hold_request = 1'b0;
	int   hold_left = 0;
	int   segment_left = 0;
	int   segment_mode = 0;

	utf16_to_utf8_transcoder_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.pop      (pop),
		.empty    (empty),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL utf16_to_utf8_transcoder_unit");
			$finish;
		end
	end

	function automatic out_item_t data_word(input logic [7:0] b);
		out_item_t w;
		w = '0;
		w.out_byte = b;
		w.byte_valid = 1'b1;
		return w;
	endfunction

	// Work out the UTF-8 words one input byte causes and queue them.
	task automatic transcode_byte(input logic [7:0] b, input logic last);
		out_item_t   words[$];
		out_item_t   closing;
		logic [15:0] unit;
		logic [20:0] cp;
		logic        bom;
		if (!lead_waiting) begin
			held_lead = b;
			lead_waiting = 1'b1;
		end else begin
			unit = cfg_little_endian ? {b, held_lead} : {held_lead, b};
			bom = awaiting_first_unit &&
				((held_lead == BOM_A && b == BOM_B) || (held_lead == BOM_B && b == BOM_A));
			lead_waiting = 1'b0;
			held_lead = '0;
			unit_seen = 1'b1;
			awaiting_first_unit = 1'b0;
			if (!bom && msg_error == ERR_OK) begin
				if (pair_open) begin
					pair_open = 1'b0;
					if (unit[15:10] == SURR_LO_TAG) begin
						cp = SUPP_BASE + {1'b0, pair_high_bits, unit[9:0]};
						words = {words, data_word(LEAD4 | {5'b0, cp[20:18]})};
						words = {words, data_word(CONT | {2'b0, cp[17:12]})};
						words = {words, data_word(CONT | {2'b0, cp[11:6]})};
						words = {words, data_word(CONT | {2'b0, cp[5:0]})};
					end else begin
						msg_error = ERR_BAD_LOW;
					end
				end else if (unit[15:10] == SURR_HI_TAG) begin
					pair_high_bits = unit[9:0];
					pair_open = 1'b1;
				end else if (unit[15:10] == SURR_LO_TAG) begin
					msg_error = ERR_LONE_LOW;
				end else if (unit <= 16'h007F) begin
					words = {words, data_word(unit[7:0])};
				end else if (unit <= 16'h07FF) begin
					words = {words, data_word(LEAD2 | {3'b0, unit[10:6]})};
					words = {words, data_word(CONT | {2'b0, unit[5:0]})};
				end else begin
					words = {words, data_word(LEAD3 | {4'b0, unit[15:12]})};
					words = {words, data_word(CONT | {2'b0, unit[11:6]})};
					words = {words, data_word(CONT | {2'b0, unit[5:0]})};
				end
			end
		end
		if (last) begin
			closing = '0;
			closing.message_end = 1'b1;
			if (lead_waiting)
				closing.error_code = unit_seen ? ERR_ODD : ERR_OK;
			else if (msg_error != ERR_OK)
				closing.error_code = msg_error;
			else if (pair_open)
				closing.error_code = ERR_TRUNC;
			else
				closing.error_code = ERR_OK;
			words = {words, closing};
			held_lead = '0;
			lead_waiting = 1'b0;
			awaiting_first_unit = 1'b1;
			unit_seen = 1'b0;
			pair_high_bits = '0;
			pair_open = 1'b0;
			msg_error = ERR_OK;
		end
		if (words.size() != 0)
			words[words.size() - 1].run_last = 1'b1;
		utf8_expect = {utf8_expect, words};
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_words
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (utf8_expect.size() == 0) begin
				report_mismatch("word with nothing pending, out_byte",
					32'(out_item.out_byte), 32'd0);
			end else begin
				want = utf8_expect.pop_front();
				if (out_item.out_byte !== want.out_byte)
					report_mismatch("out_byte", 32'(out_item.out_byte), 32'(want.out_byte));
				if (out_item.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", 32'(out_item.byte_valid),
						32'(want.byte_valid));
				if (out_item.run_last !== want.run_last)
					report_mismatch("run_last", 32'(out_item.run_last), 32'(want.run_last));
				if (out_item.message_end !== want.message_end)
					report_mismatch("message_end", 32'(out_item.message_end),
						32'(want.message_end));
				if (out_item.error_code !== want.error_code)
					report_mismatch("error_code", 32'(out_item.error_code),
						32'(want.error_code));
			end
			words_checked++;
		end
	end

	// Receiver: random stall segments, plus one long hold on request.
	initial begin
		forever begin
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (segment_left == 0) begin
				segment_left = $urandom_range(1, 40);
				segment_mode = $urandom_range(0, 2);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				segment_left--;
				case (segment_mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
			@(posedge clk);
		end
	end

	// Offer one byte; leave push high so back-to-back words need no toggle.
	task automatic send_word(input logic [7:0] b, input logic last);
		in_item_t w;
		w.in_byte = b;
		w.last_in_message = last;
		if (sender_bursty) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left--;
		end
		push <= 1'b1;
		in_item <= w;
		do @(posedge clk); while (full);
		transcode_byte(b, last);
		words_sent++;
	endtask

	task automatic send_unit(input logic [15:0] u, input logic last);
		if (cfg_little_endian) begin
			send_word(u[7:0], 1'b0);
			send_word(u[15:8], last);
		end else begin
			send_word(u[15:8], 1'b0);
			send_word(u[7:0], last);
		end
	endtask

	// Hold the input until every pending word is out and the block has gone quiet.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (utf8_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_order(input logic little);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= little;
		@(posedge clk);
		cfg_little_endian = little;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_bmp_char();
		logic [15:0] u;
		case ($urandom_range(0, 2))
			0: u = 16'($urandom_range(0, 16'h007F));
			1: u = 16'($urandom_range(16'h0080, 16'h07FF));
			default: begin
				do u = 16'($urandom_range(16'h0800, 16'hFFFF)); while (u[15:11] == 5'b11011);
			end
		endcase
		return u;
	endfunction

	task automatic send_random_char(input logic last);
		logic [9:0] hi_bits;
		logic [9:0] lo_bits;
		hi_bits = 10'($urandom_range(0, 1023));
		lo_bits = 10'($urandom_range(0, 1023));
		if ($urandom_range(0, 3) == 0) begin
			send_unit({SURR_HI_TAG, hi_bits}, 1'b0);
			send_unit({SURR_LO_TAG, lo_bits}, last);
		end else begin
			send_unit(pick_bmp_char(), last);
		end
	endtask

	task automatic send_random_message();
		int         kind;
		int         count;
		logic [9:0] bits10;
		kind = $urandom_range(0, 9);
		bits10 = 10'($urandom_range(0, 1023));
		if (kind <= 6) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 1)) begin
					send_word(BOM_A, 1'b0);
					send_word(BOM_B, 1'b0);
				end else begin
					send_word(BOM_B, 1'b0);
					send_word(BOM_A, 1'b0);
				end
			end
			count = $urandom_range(1, 5);
			for (int i = 0; i < count; i++) begin
				// set a random byte order mid-message now and then
				if (i > 0 && $urandom_range(0, 14) == 0)
					set_byte_order(1'($urandom_range(0, 1)));
				send_random_char(i == count - 1);
			end
		end else if (kind == 7) begin
			count = $urandom_range(0, 2);
			for (int i = 0; i < count; i++)
				send_random_char(1'b0);
			case ($urandom_range(0, 3))
				0: begin
					send_unit({SURR_LO_TAG, bits10}, 1'b0);
					send_random_char(1'b1);
				end
				1: begin
					send_unit({SURR_HI_TAG, bits10}, 1'b0);
					send_unit(pick_bmp_char(), 1'b0);
					send_random_char(1'b1);
				end
				2: send_unit({SURR_HI_TAG, bits10}, 1'b1);
				default: begin
					send_random_char(1'b0);
					send_word(8'($urandom_range(0, 255)), 1'b1);
				end
			endcase
		end else if (kind == 8) begin
			count = $urandom_range(1, 8);
			for (int i = 0; i < count; i++)
				send_word(8'($urandom_range(0, 255)), i == count - 1);
		end else begin
			send_word(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic test_directed_cases();
		// BOM, then every output length and a pair
		send_word(BOM_A, 1'b0);
		send_word(BOM_B, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'hDE00, 1'b1);
		// single-byte message closes clean
		send_word(8'h5A, 1'b1);
		// lone low surrogate silences the rest
		send_unit(16'hDC00, 1'b0);
		send_unit(16'h0041, 1'b1);
		// odd length wins over a bad low surrogate
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_word(8'h41, 1'b1);
		// high surrogate left open at the end
		send_unit(16'hDBFF, 1'b1);
	endtask

	task automatic test_byte_order_switch();
		set_byte_order(1'b0);
		send_word(BOM_B, 1'b0);
		send_word(BOM_A, 1'b0);
		send_unit(16'h00E9, 1'b0);
		set_byte_order(1'b1);
		send_unit(16'h20AC, 1'b1);
	endtask

	task automatic test_random_messages();
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 4) == 0)
				set_byte_order(1'($urandom_range(0, 1)));
			send_random_message();
		end
	endtask

	task automatic test_output_backpressure();
		drain_results();
		sender_bursty = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 6; i++)
			send_unit(16'h0800 + 16'(i * 16'h0111), 1'b0);
		send_unit(16'hD801, 1'b0);
		send_unit(16'hDC37, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		// pause until the held words have all come out
		drain_results();
		sender_bursty = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_byte_order_switch();
		test_random_messages();
		test_output_backpressure();
		drain_results();
		if (mismatches == 0)
			$display("PASS utf16_to_utf8_transcoder_unit");
		else
			$display("FAIL utf16_to_utf8_transcoder_unit");
		$finish;
	end

endmodule

// ===== utf16_to_utf8_transcoder_unit.f =====
+incdir+hdl
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_jobq.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_transcoder_unit.sv
sim/utf16_to_utf8_transcoder_unit_tb.sv
